@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define JFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// Condition must never be true on a clock edge outside reset.
`define JFP_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen: %m");

`endif

@@ hdl/jfp_pkg.sv @@
// ----------------------------------------------------------------------------
// jfp_pkg
// Types, codes and constants of the JFIF frame header parser.
// ----------------------------------------------------------------------------
package jfp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [3:0]  PosSat     = 4'd12;
  localparam logic [3:0]  PosHeadEnd = 4'd11;
  localparam logic [3:0]  PosLenHi   = 4'd4;
  localparam logic [3:0]  PosLenLo   = 4'd5;
  localparam logic [3:0]  PosJpegEnd = 4'd2;

  localparam logic [15:0] MarkerSof0 = 16'hFFC0;
  localparam logic [15:0] MarkerSofE = 16'hFFCF;
  localparam logic [15:0] MarkerSos  = 16'hFFDA;
  localparam logic [7:0]  MarkerPfx  = 8'hFF;
  localparam logic [7:0]  EoiLow     = 8'hD9;
  localparam logic [15:0] MinSegLen  = 16'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_JPEG = 3'd1,
    ST_NOT_JFIF = 3'd2,
    ST_PARSE    = 3'd3,
    ST_BAD_COMP = 3'd4
  } jfp_status_e;

  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_SKIP   = 3'd1,
    PH_MARKER = 3'd2,
    PH_SOF    = 3'd3,
    PH_DONE   = 3'd4
  } jfp_phase_e;

  // Field offsets inside the SOF segment, counted from the first length byte after the marker.
  localparam logic [2:0] SofPrec  = 3'd2;
  localparam logic [2:0] SofHgtHi = 3'd3;
  localparam logic [2:0] SofHgtLo = 3'd4;
  localparam logic [2:0] SofWidHi = 3'd5;
  localparam logic [2:0] SofWidLo = 3'd6;
  localparam logic [2:0] SofComp  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } jfp_in_t;

  typedef struct packed {
    jfp_status_e status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  channel_count;
    logic [7:0]  sample_precision;
  } jfp_out_t;

  // One classified byte as handed from the front end to the segment walker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       walk;       // offset 4 or later
    logic       short_file; // offset below 11
    logic       ends_eoi;   // this byte closes an FFD9 pair
    logic       start_ok;   // SOI check so far, this byte included
    logic       jfif_ok;    // APP0/JFIF check so far, this byte included
  } jfp_tok_t;

  // Expected file bytes at the start; the APP0 length bytes are not compared.
  function automatic logic [7:0] head_byte(input logic [3:0] pos);
    logic [7:0] v;
    case (pos)
      4'd0:    v = 8'hFF;
      4'd1:    v = 8'hD8;
      4'd2:    v = 8'hFF;
      4'd3:    v = 8'hE0;
      4'd6:    v = 8'h4A;
      4'd7:    v = 8'h46;
      4'd8:    v = 8'h49;
      4'd9:    v = 8'h46;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/jfp_front.sv @@
// ----------------------------------------------------------------------------
// jfp_front
// Accepts file bytes, checks the fixed header and the end marker, and tags
// each byte for the segment walker.
// ----------------------------------------------------------------------------
module jfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jfp_pkg::jfp_in_t  in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output jfp_pkg::jfp_tok_t q_tok_o
);
  import jfp_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [7:0] prev_q, prev_d;
  logic       start_ok_q, start_ok_d;
  logic       jfif_ok_q, jfif_ok_d;
  logic       checked, mismatch;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    checked  = (pos_q < PosHeadEnd) && (pos_q != PosLenHi) && (pos_q != PosLenLo);
    mismatch = checked && (in_data_i.data_byte != head_byte(pos_q));

    start_ok_d = start_ok_q;
    jfif_ok_d  = jfif_ok_q;
    if (mismatch) begin
      if (pos_q < PosJpegEnd) begin
        start_ok_d = 1'b0;
      end else begin
        jfif_ok_d = 1'b0;
      end
    end

    q_tok_o.data_byte  = in_data_i.data_byte;
    q_tok_o.last_byte  = in_data_i.last_byte;
    q_tok_o.walk       = (pos_q >= PosLenHi);
    q_tok_o.short_file = (pos_q < PosHeadEnd);
    q_tok_o.ends_eoi   = (pos_q != 4'd0) && (prev_q == MarkerPfx)
                         && (in_data_i.data_byte == EoiLow);
    q_tok_o.start_ok   = start_ok_d;
    q_tok_o.jfif_ok    = jfif_ok_d;

    pos_d  = (pos_q < PosSat) ? pos_q + 4'd1 : pos_q;
    prev_d = in_data_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_q     <= '0;
      start_ok_q <= 1'b1;
      jfif_ok_q  <= 1'b1;
    end else if (q_push_o) begin
      if (in_data_i.last_byte) begin
        pos_q      <= '0;
        prev_q     <= '0;
        start_ok_q <= 1'b1;
        jfif_ok_q  <= 1'b1;
      end else begin
        pos_q      <= pos_d;
        prev_q     <= prev_d;
        start_ok_q <= start_ok_d;
        jfif_ok_q  <= jfif_ok_d;
      end
    end
  end

  `include "assert_macros.svh"

  `JFP_ASSERT(a_pos_sat, clk_i, rst_ni, pos_q <= PosSat)
  `JFP_NEVER(a_jpeg_before_jfif, clk_i, rst_ni, (pos_q < PosJpegEnd) && !jfif_ok_q)

endmodule

@@ hdl/jfp_queue.sv @@
// ----------------------------------------------------------------------------
// jfp_queue
// Small FIFO of classified bytes between the front end and the walker.
// ----------------------------------------------------------------------------
module jfp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jfp_pkg::jfp_tok_t push_tok_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output jfp_pkg::jfp_tok_t pop_tok_o
);
  import jfp_pkg::*;

  jfp_tok_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o      = (count_q == (QPtrW+1)'(QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_tok_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `include "assert_macros.svh"

  `JFP_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `JFP_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !pop_valid_o)

endmodule

@@ hdl/jfp_back.sv @@
// ----------------------------------------------------------------------------
// jfp_back
// Walks the marker segments, captures the SOF fields and builds the result
// on the final byte of the file.
// ----------------------------------------------------------------------------
module jfp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  jfp_pkg::jfp_tok_t tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jfp_pkg::jfp_out_t out_data_o
);
  import jfp_pkg::*;

  jfp_phase_e  phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  word_hi_q, word_hi_d;
  logic [2:0]  field_q, field_d;
  logic        failed_q, failed_d;
  logic        found_q, found_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  prec_q, prec_d;
  logic [7:0]  comp_q, comp_d;
  logic [15:0] word;
  logic        out_free;
  logic        emit;
  jfp_status_e status;
  jfp_out_t    res;
  jfp_out_t    out_q;
  logic        out_valid_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign tok_pop_o   = tok_valid_i && (!tok_i.last_byte || out_free);
  assign emit        = tok_pop_o && tok_i.last_byte;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    word      = {word_hi_q, tok_i.data_byte};
    phase_d   = phase_q;
    skip_d    = skip_q;
    word_hi_d = word_hi_q;
    field_d   = field_q;
    failed_d  = failed_q;
    found_d   = found_q;
    width_d   = width_q;
    height_d  = height_q;
    prec_d    = prec_q;
    comp_d    = comp_q;

    if (tok_i.walk) begin
      case (phase_q)
        PH_LEN: begin
          if (field_q == '0) begin
            word_hi_d = tok_i.data_byte;
            field_d   = 3'd1;
          end else begin
            field_d = '0;
            if (word <= MinSegLen) begin
              failed_d = 1'b1;
              phase_d  = PH_DONE;
            end else begin
              skip_d  = word - MinSegLen;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_d == '0) begin
            phase_d = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (field_q == '0) begin
            word_hi_d = tok_i.data_byte;
            field_d   = 3'd1;
          end else begin
            field_d = '0;
            if ((word >= MarkerSof0) && (word < MarkerSofE)) begin
              phase_d = PH_SOF;
            end else if (word == MarkerSos) begin
              failed_d = 1'b1;
              phase_d  = PH_DONE;
            end else begin
              phase_d = PH_LEN;
            end
          end
        end
        PH_SOF: begin
          case (field_q)
            SofPrec:  prec_d    = tok_i.data_byte;
            SofHgtHi: word_hi_d = tok_i.data_byte;
            SofHgtLo: height_d  = word;
            SofWidHi: word_hi_d = tok_i.data_byte;
            SofWidLo: width_d   = word;
            SofComp: begin
              comp_d  = tok_i.data_byte;
              found_d = 1'b1;
              phase_d = PH_DONE;
            end
            default: ;
          endcase
          field_d = field_q + 3'd1;
        end
        default: ;
      endcase
    end

    if (!tok_i.start_ok || !tok_i.ends_eoi) begin
      status = ST_NOT_JPEG;
    end else if (!tok_i.jfif_ok || tok_i.short_file) begin
      status = ST_NOT_JFIF;
    end else if (failed_d || !found_d) begin
      status = ST_PARSE;
    end else if ((comp_d != 8'd1) && (comp_d != 8'd3)) begin
      status = ST_BAD_COMP;
    end else begin
      status = ST_OK;
    end

    res.status           = status;
    res.image_width      = (status == ST_OK) ? width_d  : '0;
    res.image_height     = (status == ST_OK) ? height_d : '0;
    res.channel_count    = (status == ST_OK) ? comp_d   : '0;
    res.sample_precision = (status == ST_OK) ? prec_d   : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      skip_q    <= '0;
      word_hi_q <= '0;
      field_q   <= '0;
      failed_q  <= 1'b0;
      found_q   <= 1'b0;
    end else if (tok_pop_o) begin
      if (tok_i.last_byte) begin
        phase_q   <= PH_LEN;
        skip_q    <= '0;
        word_hi_q <= '0;
        field_q   <= '0;
        failed_q  <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        skip_q    <= skip_d;
        word_hi_q <= word_hi_d;
        field_q   <= field_d;
        failed_q  <= failed_d;
        found_q   <= found_d;
      end
    end
  end

  // Captured SOF fields only matter once found_q is set, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      width_q  <= width_d;
      height_q <= height_d;
      prec_q   <= prec_d;
      comp_q   <= comp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  `include "assert_macros.svh"

  `JFP_NEVER(a_found_and_failed, clk_i, rst_ni, found_q && failed_q)
  `JFP_ASSERT(a_ok_components, clk_i, rst_ni,
    (out_valid_q && (out_q.status == ST_OK)) |->
      ((out_q.channel_count == 8'd1) || (out_q.channel_count == 8'd3)))
  `JFP_ASSERT(a_error_zeroed, clk_i, rst_ni,
    (out_valid_q && (out_q.status != ST_OK)) |->
      ((out_q.image_width == '0) && (out_q.image_height == '0)))
  `JFP_ASSERT(a_skip_nonzero, clk_i, rst_ni, (phase_q == PH_SKIP) |-> (skip_q != '0))

endmodule

@@ hdl/jfif_frame_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// jfif_frame_header_parser_top
// Streams a JPEG file byte by byte, checks the SOI/APP0/JFIF header and the
// closing EOI marker, walks the marker segments and reports the frame size
// found in the first SOF segment.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   jfp_in_t  (byte, last flag)
//   out      output     out_valid_o / out_stall_i jfp_out_t (status, frame)
//
// A new byte can be accepted in every cycle while the queue is not full.
// The front end checks the fixed header and the EOI pair and tags each byte.
// A four-entry queue lets the front end keep accepting while the result
// register is held by a stalled output; input stalls only when it fills.
// The walker retires one byte per cycle, but a file's final byte waits for
// the result register, and the result shows the cycle after it is popped.
// Reset returns every part to the start of a new file; no clearing pass.
//
// Exactly one transaction leaves the output per file, on the final byte.
// Status codes: ok, not JPEG, not JFIF, parse error, bad component count;
// the frame fields are zero unless the status is ok.
// ----------------------------------------------------------------------------
module jfif_frame_header_parser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jfp_pkg::jfp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jfp_pkg::jfp_out_t out_data_o
);
  import jfp_pkg::*;

  // Classified byte from the front end into the queue.
  logic     q_push;
  logic     q_full;
  jfp_tok_t q_push_tok;

  // Queue head toward the segment walker.
  logic     q_pop;
  logic     q_valid;
  jfp_tok_t q_head_tok;

  jfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_tok_o    (q_push_tok)
  );

  jfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_tok_i  (q_push_tok),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_tok_o   (q_head_tok)
  );

  // The walker pops ordinary bytes freely; the final byte of a file waits
  // until the result register can take its transaction.
  jfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_head_tok),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
